### rtl/ntt_pkg.sv
// Shared types and constants for the number theoretic transform block.
package ntt_pkg;

	localparam int MAX_LENGTH_DEF = 64;
	localparam int WORD_WIDTH_DEF = 64;
	localparam int LEN_CFG_W      = 7;
	localparam int INDEX_W        = 6;
	localparam int CFG_IDX_W      = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERSE   = 2'd3;

	localparam longint unsigned MODULUS_RST   = 64'd998244353;
	localparam longint unsigned GENERATOR_RST = 64'd3;
	localparam logic [LEN_CFG_W-1:0] LENGTH_RST = 7'd64;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV
	} mop_t;

	typedef struct packed {
		logic start;
		mop_t op;
	} mreq_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ZERO,
		S_GRED,
		S_LRED,
		S_PCHK,
		S_PMR,
		S_PSQ,
		S_DIV,
		S_ROW,
		S_RD,
		S_XRED,
		S_PROD,
		S_TW,
		S_SCL,
		S_EMIT,
		S_WN
	} state_t;

	typedef enum logic [1:0] {
		P_SCALE,
		P_GINV,
		P_ROOT
	} pret_t;

endpackage

### rtl/ntt_mod_unit.sv
// Bit-serial modular multiplier and small restoring divider, one bit per cycle.
module ntt_mod_unit #(
	parameter int W = ntt_pkg::WORD_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ntt_pkg::mreq_t  req,
	input  logic [W-1:0]    a,
	input  logic [W-1:0]    b,
	input  logic [W-1:0]    m,
	output logic            done,
	output logic [W-1:0]    result
);
	import ntt_pkg::*;

	localparam int CW = $clog2(W);

	logic          busy_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  r_q, b_q, a_q, m_q;
	mop_t          op_q;
	logic [W-1:0]  r2, r_nx, t;
	logic          ge;

	// x + y mod m, both below m
	function automatic logic [W-1:0] addm(input logic [W-1:0] x, y, mm);
		logic [W-1:0] room;
		room = mm - y;
		return (x >= room) ? (x - room) : (x + y);
	endfunction

	always_comb begin
		r2   = addm(r_q, r_q, m_q);
		t    = {r_q[W-2:0], b_q[W-1]};
		ge   = (t >= m_q);
		r_nx = b_q[W-1] ? addm(r2, a_q, m_q) : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			r_q  <= '0;
			a_q  <= a;
			b_q  <= b;
			m_q  <= m;
			op_q <= req.op;
		end else if (busy_q) begin
			unique case (op_q)
				OP_MUL: begin
					r_q <= r_nx;
					b_q <= {b_q[W-2:0], 1'b0};
				end
				OP_DIV: begin
					r_q <= ge ? (t - m_q) : t;
					b_q <= {b_q[W-2:0], ge};
				end
				default: begin
					r_q <= r_q;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = (op_q == OP_DIV) ? b_q : r_q;

endmodule

### rtl/number_theoretic_transform.sv
// Top level of the direct number theoretic transform block.
//
// Usage: samples arrive on the request channel (start/busy/sample); a request
// is taken at a clock edge with start high and busy low. Samples fill a
// sample memory from index zero. The request that brings the count up to
// the configured length starts the transform and raises busy.
// Results leave one at a time on coefficient/out_index/last, each valid for
// exactly one cycle with out_valid high; the receiver cannot stall them.
// Outputs come in index order, last marks the final one, then busy drops.
// Cost: all modular work runs through one bit-serial unit, one multiply at
// a time. Root setup takes one modular power forward and three in inverse
// mode. Each output then takes len sample steps (reduce, multiply, advance
// twiddle) and one root step, plus a scaling multiply in inverse mode.
// Modulus below two: len zero outputs, one per cycle.
// Configuration: write port cfg_valid/cfg_ready/cfg_index/cfg_data, always
// ready; write only while the block is idle.
// Reset: registers return to their defaults, load count clears; sample
// memory contents are undefined until loaded.
module number_theoretic_transform #(
	parameter int MAX_LENGTH = ntt_pkg::MAX_LENGTH_DEF,
	parameter int WORD_WIDTH = ntt_pkg::WORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [WORD_WIDTH-1:0]         sample,
	output logic                          out_valid,
	output logic [WORD_WIDTH-1:0]         coefficient,
	output logic [ntt_pkg::INDEX_W-1:0]   out_index,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ntt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_WIDTH-1:0]         cfg_data
);
	import ntt_pkg::*;

	localparam int W  = WORD_WIDTH;
	localparam int LW = $clog2(MAX_LENGTH + 1);
	localparam int AW = $clog2(MAX_LENGTH);

	// configuration registers
	logic [W-1:0]         mod_q, gen_q;
	logic [LEN_CFG_W-1:0] len_cfg_q;
	logic                 inv_q;

	// sample memory, one write port at load, one registered read port
	logic [W-1:0] mem [MAX_LENGTH];
	logic [W-1:0] rd_data;

	state_t state_q, state_d;
	pret_t  pret_q;
	logic   issued_q;

	logic [LW-1:0] load_cnt_q, n_q, k_q, len_eff;
	logic [W-1:0]  g_q, scale_q, w_q, wn_q, tw_q, sum_q, x_q;
	logic [W-1:0]  pr_q, pb_q, pe_q;
	logic [W-1:0]  len_ext, sum_add;

	mreq_t        mreq;
	logic [W-1:0] op_a, op_b, op_m, mres;
	logic         mdone, arith, accept, load_done, k_last, n_last;

	function automatic logic [W-1:0] addm(input logic [W-1:0] x, y, mm);
		logic [W-1:0] room;
		room = mm - y;
		return (x >= room) ? (x - room) : (x + y);
	endfunction

	// length clamp: zero acts as one, above the maximum acts as the maximum
	always_comb begin
		if (len_cfg_q == '0)
			len_eff = LW'(1);
		else if (32'(len_cfg_q) > MAX_LENGTH)
			len_eff = LW'(MAX_LENGTH);
		else
			len_eff = LW'(len_cfg_q);
	end

	assign len_ext   = W'(len_eff);
	assign accept    = start && (state_q == S_IDLE);
	assign load_done = (load_cnt_q + 1'b1) >= len_eff;
	assign k_last    = (k_q == len_eff - 1'b1);
	assign n_last    = (n_q == len_eff - 1'b1);
	assign sum_add   = addm(sum_q, mres, mod_q);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q     <= W'(MODULUS_RST);
			gen_q     <= W'(GENERATOR_RST);
			len_cfg_q <= LENGTH_RST;
			inv_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MODULUS:   mod_q     <= cfg_data;
				CFG_GENERATOR: gen_q     <= cfg_data;
				CFG_LENGTH:    len_cfg_q <= cfg_data[LEN_CFG_W-1:0];
				CFG_INVERSE:   inv_q     <= cfg_data[0];
				default:       inv_q     <= inv_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			mem[load_cnt_q[AW-1:0]] <= sample;
		rd_data <= mem[k_q[AW-1:0]];
	end

	ntt_mod_unit #(.W(W)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.a      (op_a),
		.b      (op_b),
		.m      (op_m),
		.done   (mdone),
		.result (mres)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && load_done)
					state_d = (mod_q < W'(2)) ? S_ZERO : S_GRED;
			end
			S_ZERO: if (n_last) state_d = S_IDLE;
			S_GRED: if (mdone) state_d = inv_q ? S_LRED : S_DIV;
			S_LRED: if (mdone) state_d = S_PCHK;
			S_PCHK: begin
				if (pe_q == '0) begin
					unique case (pret_q)
						P_SCALE: state_d = S_PCHK;
						P_GINV:  state_d = S_DIV;
						P_ROOT:  state_d = S_ROW;
						default: state_d = S_IDLE;
					endcase
				end else begin
					state_d = pe_q[0] ? S_PMR : S_PSQ;
				end
			end
			S_PMR:  if (mdone) state_d = S_PSQ;
			S_PSQ:  if (mdone) state_d = S_PCHK;
			S_DIV:  if (mdone) state_d = S_PCHK;
			S_ROW:  state_d = S_RD;
			S_RD:   state_d = S_XRED;
			S_XRED: if (mdone) state_d = S_PROD;
			S_PROD: if (mdone) state_d = S_TW;
			S_TW: begin
				if (mdone)
					state_d = k_last ? (inv_q ? S_SCL : S_EMIT) : S_RD;
			end
			S_SCL:  if (mdone) state_d = S_EMIT;
			S_EMIT: state_d = n_last ? S_IDLE : S_WN;
			S_WN:   if (mdone) state_d = S_ROW;
			default: state_d = S_IDLE;
		endcase
	end

	// unit operands and port outputs
	always_comb begin
		arith   = 1'b1;
		mreq.op = OP_MUL;
		op_a    = W'(1);
		op_b    = '0;
		op_m    = mod_q;
		unique case (state_q)
			S_GRED: op_b = gen_q;
			S_LRED: op_b = len_ext;
			S_PMR: begin
				op_a = pr_q;
				op_b = pb_q;
			end
			S_PSQ: begin
				op_a = pb_q;
				op_b = pb_q;
			end
			S_DIV: begin
				mreq.op = OP_DIV;
				op_b    = mod_q - 1'b1;
				op_m    = len_ext;
			end
			S_XRED: op_b = rd_data;
			S_PROD: begin
				op_a = x_q;
				op_b = tw_q;
			end
			S_TW: begin
				op_a = tw_q;
				op_b = wn_q;
			end
			S_SCL: begin
				op_a = sum_q;
				op_b = scale_q;
			end
			S_WN: begin
				op_a = wn_q;
				op_b = w_q;
			end
			default: arith = 1'b0;
		endcase
		mreq.start  = arith && !issued_q;
		busy        = (state_q != S_IDLE);
		out_valid   = (state_q == S_EMIT) || (state_q == S_ZERO);
		coefficient = sum_q;
		out_index   = INDEX_W'(n_q);
		last        = n_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			issued_q   <= 1'b0;
			load_cnt_q <= '0;
			n_q        <= '0;
			k_q        <= '0;
			pret_q     <= P_SCALE;
		end else begin
			state_q <= state_d;
			if (mdone)
				issued_q <= 1'b0;
			else if (mreq.start)
				issued_q <= 1'b1;
			if (accept)
				load_cnt_q <= load_done ? '0 : load_cnt_q + 1'b1;
			unique case (state_q)
				S_IDLE: n_q <= '0;
				S_ZERO: n_q <= n_q + 1'b1;
				S_LRED: pret_q <= P_SCALE;
				S_PCHK: begin
					if (pe_q == '0 && pret_q == P_SCALE)
						pret_q <= P_GINV;
				end
				S_DIV:  if (mdone) pret_q <= P_ROOT;
				S_ROW:  k_q <= '0;
				S_TW:   if (mdone && !k_last) k_q <= k_q + 1'b1;
				S_WN:   if (mdone) n_q <= n_q + 1'b1;
				default: k_q <= k_q;
			endcase
		end
	end

	// data path registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: sum_q <= '0;
			S_GRED: begin
				if (mdone) begin
					g_q     <= mres;
					scale_q <= W'(1);
				end
			end
			S_LRED: begin
				if (mdone) begin
					pb_q <= mres;
					pr_q <= W'(1);
					pe_q <= mod_q - W'(2);
				end
			end
			S_PCHK: begin
				if (pe_q == '0) begin
					unique case (pret_q)
						P_SCALE: begin
							scale_q <= pr_q;
							pb_q    <= g_q;
							pr_q    <= W'(1);
							pe_q    <= mod_q - W'(2);
						end
						P_GINV: g_q <= pr_q;
						P_ROOT: begin
							w_q  <= pr_q;
							wn_q <= W'(1);
						end
						default: w_q <= w_q;
					endcase
				end
			end
			S_PMR: if (mdone) pr_q <= mres;
			S_PSQ: begin
				if (mdone) begin
					pb_q <= mres;
					pe_q <= pe_q >> 1;
				end
			end
			S_DIV: begin
				if (mdone) begin
					pb_q <= g_q;
					pr_q <= W'(1);
					pe_q <= mres;
				end
			end
			S_ROW: begin
				sum_q <= '0;
				tw_q  <= W'(1);
			end
			S_XRED: if (mdone) x_q <= mres;
			S_PROD: if (mdone) sum_q <= sum_add;
			S_TW:   if (mdone) tw_q <= mres;
			S_SCL:  if (mdone) sum_q <= mres;
			S_WN:   if (mdone) wn_q <= mres;
			default: x_q <= x_q;
		endcase
	end

endmodule
